/* rtl/pell_fundamental_solution_macros.svh */
// Assertion macros for the Pell solver. Each use sits on a line of its own.
`ifndef PELL_FUNDAMENTAL_SOLUTION_MACROS_SVH
`define PELL_FUNDAMENTAL_SOLUTION_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pfs_pkg.sv */
`timescale 1ns / 1ps
package pfs_pkg;
	localparam int NW = 63;
	localparam int DEF_MAX_TERMS = 128;
	localparam int DEF_RADICAND_BITS = 40;
	localparam logic [NW-1:0] NUM_BOUND = 63'd4000000000000000000;
endpackage

/* rtl/pell_fundamental_solution.sv */
// Order of work: the square root, then the first denominator term, then each further term
// up to MAX_TERMS terms, on a serial shift-add/restoring-divide datapath whose term
// registers are AW = ceil(RADICAND_BITS/2) + 2 bits wide. One word at a time: busy stays
// high until the result strobe, and a new word may be taken in the strobe cycle.
// Reset (arst_n low) returns the sequencer to idle and drops busy and done at once.
`timescale 1ns / 1ps
`include "pell_fundamental_solution_macros.svh"
module pell_fundamental_solution #(
	parameter int MAX_TERMS = pfs_pkg::DEF_MAX_TERMS,
	parameter int RADICAND_BITS = pfs_pkg::DEF_RADICAND_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [RADICAND_BITS-1:0] radicand,
	output logic                     done,
	output logic [pfs_pkg::NW-1:0]   x_solution,
	output logic [pfs_pkg::NW-1:0]   y_solution,
	output logic                     found
);
	import pfs_pkg::*;

	localparam int RB = RADICAND_BITS;
	localparam int AW = (RB + 1) / 2 + 2;
	localparam int PW = NW + AW + 1;
	localparam int CW = $clog2(RB + 1);
	localparam int TW = $clog2(MAX_TERMS);
	localparam int TOPB = ((RB - 1) / 2) * 2;
	localparam int SQ_STEPS = TOPB / 2 + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_SQRT, S_INIT, S_LD_DA, S_MUL_DA, S_SUB_M, S_MUL_MM, S_SUB_DV,
		S_DIV_D, S_WR_D, S_ADD_AM, S_DIV_A, S_WR_A, S_MUL_N, S_CHK_N, S_MUL_K,
		S_WR_K, S_TEST
	} state_t;

	state_t state_q;
	logic [RB-1:0] dv_q;
	logic [AW-1:0] a0_q, m_q, d_q, a_q, ml_q, rem_q;
	logic [NW-1:0] n0_q, n1_q, k0_q, k1_q;
	logic [PW-1:0] acc_q, mcs_q;
	logic [RB-1:0] dq_q;
	logic [CW-1:0] cnt_q;
	logic [TW-1:0] i_q;
	logic          nxt_q;
	logic          done_q, found_q;
	logic [NW-1:0] x_q, y_q;

	// Shared adder: subtracts when add_sub is set, carry out means no borrow.
	logic [PW-1:0] add_x, add_y;
	logic          add_sub;
	logic [PW:0]   sum;
	logic [PW-1:0] sum_r;
	logic          carry;
	logic [AW:0]   trial;

	always_comb begin
		add_x = '0;
		add_y = '0;
		add_sub = 1'b0;
		trial = {rem_q, dq_q[RB-1]};
		unique case (state_q)
			S_SQRT: begin
				add_x = PW'(acc_q[RB-1:0]);
				add_y = PW'(mcs_q[RB-1:0] | dq_q);
				add_sub = 1'b1;
			end
			S_MUL_DA, S_MUL_MM, S_MUL_N, S_MUL_K: begin
				add_x = acc_q;
				add_y = mcs_q;
			end
			S_SUB_M: begin
				add_x = acc_q;
				add_y = PW'(m_q);
				add_sub = 1'b1;
			end
			S_SUB_DV: begin
				add_x = PW'(dv_q);
				add_y = acc_q;
				add_sub = 1'b1;
			end
			S_DIV_D, S_DIV_A: begin
				add_x = PW'(trial);
				add_y = PW'(d_q);
				add_sub = 1'b1;
			end
			S_ADD_AM: begin
				add_x = PW'(a0_q);
				add_y = PW'(m_q);
			end
			S_TEST: begin
				add_x = PW'(NUM_BOUND);
				add_y = PW'(n0_q);
				add_sub = 1'b1;
			end
			default: begin
				add_x = '0;
			end
		endcase
		sum = {1'b0, add_x} + {1'b0, add_y ^ {PW{add_sub}}} + (PW+1)'(add_sub);
		sum_r = sum[PW-1:0];
		carry = sum[PW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			nxt_q <= 1'b0;
			i_q <= '0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						dv_q <= radicand;
						acc_q <= PW'(radicand);
						mcs_q <= '0;
						dq_q <= RB'(1) << TOPB;
						cnt_q <= CW'(SQ_STEPS);
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					// The root and the trial bit never overlap, so OR serves as add.
					if (carry) begin
						acc_q <= sum_r;
						mcs_q <= (mcs_q >> 1) | PW'(dq_q);
					end else begin
						mcs_q <= mcs_q >> 1;
					end
					dq_q <= dq_q >> 2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= S_INIT;
				end
				S_INIT: begin
					a0_q <= mcs_q[AW-1:0];
					a_q <= mcs_q[AW-1:0];
					m_q <= '0;
					d_q <= AW'(1);
					n1_q <= NW'(1);
					n0_q <= NW'(mcs_q[AW-1:0]);
					k1_q <= '0;
					k0_q <= NW'(1);
					i_q <= '0;
					nxt_q <= 1'b0;
					state_q <= S_LD_DA;
				end
				S_LD_DA: begin
					acc_q <= '0;
					mcs_q <= PW'(d_q);
					ml_q <= a_q;
					cnt_q <= CW'(AW);
					state_q <= S_MUL_DA;
				end
				S_MUL_DA, S_MUL_MM, S_MUL_N, S_MUL_K: begin
					if (ml_q[0]) acc_q <= sum_r;
					mcs_q <= mcs_q << 1;
					ml_q <= ml_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						unique case (state_q)
							S_MUL_DA: state_q <= S_SUB_M;
							S_MUL_MM: state_q <= S_SUB_DV;
							S_MUL_N:  state_q <= S_CHK_N;
							default:  state_q <= S_WR_K;
						endcase
					end
				end
				S_SUB_M: begin
					m_q <= sum_r[AW-1:0];
					acc_q <= '0;
					mcs_q <= PW'(sum_r[AW-1:0]);
					ml_q <= sum_r[AW-1:0];
					cnt_q <= CW'(AW);
					state_q <= S_MUL_MM;
				end
				S_SUB_DV: begin
					dq_q <= sum_r[RB-1:0];
					rem_q <= '0;
					cnt_q <= CW'(RB);
					state_q <= S_DIV_D;
				end
				S_DIV_D, S_DIV_A: begin
					if (carry) begin
						rem_q <= sum_r[AW-1:0];
						dq_q <= {dq_q[RB-2:0], 1'b1};
					end else begin
						rem_q <= trial[AW-1:0];
						dq_q <= {dq_q[RB-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= (state_q == S_DIV_D) ? S_WR_D : S_WR_A;
				end
				S_WR_D: begin
					d_q <= dq_q[AW-1:0];
					if (nxt_q) begin
						state_q <= S_TEST;
					end else if (dq_q == '0) begin
						x_q <= '0;
						y_q <= '0;
						found_q <= 1'b0;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ADD_AM;
					end
				end
				S_ADD_AM: begin
					dq_q <= RB'(sum_r[AW-1:0]);
					rem_q <= '0;
					cnt_q <= CW'(RB);
					state_q <= S_DIV_A;
				end
				S_WR_A: begin
					a_q <= dq_q[AW-1:0];
					acc_q <= PW'(n1_q);
					mcs_q <= PW'(n0_q);
					ml_q <= dq_q[AW-1:0];
					cnt_q <= CW'(AW);
					state_q <= S_MUL_N;
				end
				S_CHK_N: begin
					// A numerator that does not fit in 63 bits ends the search.
					if (acc_q[PW-1:NW] != '0) begin
						x_q <= '0;
						y_q <= '0;
						found_q <= 1'b0;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						n1_q <= n0_q;
						n0_q <= acc_q[NW-1:0];
						acc_q <= PW'(k1_q);
						mcs_q <= PW'(k0_q);
						ml_q <= a_q;
						cnt_q <= CW'(AW);
						state_q <= S_MUL_K;
					end
				end
				S_WR_K: begin
					k1_q <= k0_q;
					k0_q <= acc_q[NW-1:0];
					nxt_q <= 1'b1;
					state_q <= S_LD_DA;
				end
				S_TEST: begin
					// n^2 - D*k^2 equals (-1)^i times the next denominator term, so the
					// convergent solves the equation when i is even and that term is one.
					if (!i_q[0] && d_q == AW'(1)) begin
						x_q <= n0_q;
						y_q <= k0_q;
						found_q <= 1'b1;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (!carry || i_q == TW'(MAX_TERMS - 1) || d_q == '0) begin
						x_q <= '0;
						y_q <= '0;
						found_q <= 1'b0;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_ADD_AM;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign x_solution = x_q;
	assign y_solution = y_q;
	assign found = found_q;

	`PFS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`PFS_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe lasted more than one cycle")
	`PFS_ASSERT_NOW(a_found_nonzero, done && found, x_solution != '0 && y_solution != '0, "found with zero pair")
	`PFS_ASSERT_NOW(a_miss_zero, done && !found, x_solution == '0 && y_solution == '0, "miss with nonzero pair")
endmodule

/* verif/tb_pell_fundamental_solution.sv */
`timescale 1ns / 1ps
module tb_pell_fundamental_solution;
	import pfs_pkg::*;

	localparam int RB = DEF_RADICAND_BITS;
	localparam int TERMS = DEF_MAX_TERMS;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		bit [NW-1:0] x;
		bit [NW-1:0] y;
		bit          ok;
	} pell_pair_t;

	class pell_scoreboard;
		pell_pair_t pending[$];
		int errors = 0;

		function bit [63:0] isqrt(bit [63:0] v);
			bit [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// Exact test of n^2 == D*k^2 + 1, with no wrap below 2^128.
		function bit holds(bit [63:0] dv, bit [63:0] n, bit [63:0] k);
			bit [199:0] lhs, rhs;
			lhs = 200'(n) * 200'(n);
			rhs = 200'(dv) * 200'(k) * 200'(k) + 200'd1;
			return (rhs[199:128] == 0) && (lhs == rhs);
		endfunction

		function pell_pair_t solve_pell(bit [63:0] dv);
			pell_pair_t r;
			bit [63:0] a0, m, d, a, n0, n1, n2, k0, k1, k2, nn;
			bit [127:0] prod;
			r.x = 0; r.y = 0; r.ok = 0;
			a0 = isqrt(dv);
			m = 0; d = 1; a = a0;
			n1 = 1; n0 = a0; k1 = 0; k0 = 1;
			for (int i = 0; i < TERMS; i++) begin
				m = d * a - m;
				d = (dv - m * m) / d;
				if (d == 0) break;
				a = (a0 + m) / d;
				n2 = n1; k2 = k1;
				n1 = n0; k1 = k0;
				prod = 128'(a) * 128'(n1);
				nn = prod[63:0] + n2;
				if (prod[127:64] != 0 || nn < prod[63:0] || nn[63]) break;
				n0 = nn;
				k0 = a * k1 + k2;
				if (holds(dv, n0, k0)) begin
					r.x = n0[NW-1:0]; r.y = k0[NW-1:0]; r.ok = 1;
					break;
				end
				if (n0 > 64'(NUM_BOUND)) break;
			end
			return r;
		endfunction

		function void note(bit [RB-1:0] dv);
			pending.push_back(solve_pell(64'(dv)));
		endfunction

		task report(string what, bit [NW-1:0] got, bit [NW-1:0] want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
			errors++;
		endtask

		task check(bit [NW-1:0] x, bit [NW-1:0] y, bit f);
			pell_pair_t e;
			if (pending.size() == 0) begin
				$display("unexpected result word x=%0d y=%0d at %0t", x, y, $time);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (x != e.x) report("x_solution", x, e.x);
			if (y != e.y) report("y_solution", y, e.y);
			if (f != e.ok) report("found", NW'(f), NW'(e.ok));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [RB-1:0] radicand = '0;
	logic busy, done, found;
	logic [NW-1:0] x_solution, y_solution;

	pell_scoreboard sb = new();
	int idle_pct = 22;
	int stall = 0;

	pell_fundamental_solution dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .radicand(radicand),
		.done(done), .x_solution(x_solution), .y_solution(y_solution), .found(found)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check(x_solution, y_solution, found);
		if ((start && !busy) || done) begin
			stall <= 0;
		end else if (arst_n) begin
			stall <= stall + 1;
			if (stall >= STALL_LIMIT) begin
				$display("tb_pell_fundamental_solution: FAIL");
				$finish;
			end
		end
	end

	task send_word(bit [RB-1:0] v);
		start <= 1;
		radicand <= v;
		@(posedge clk);
		while (!(start && !busy)) @(posedge clk);
		sb.note(v);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function bit [RB-1:0] random_radicand();
		bit [63:0] r, s;
		int w;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0: begin
				s = 64'($urandom_range(0, 1048575));
				return RB'(s * s);
			end
			1, 2: return RB'(r);
			default: begin
				w = $urandom_range(2, RB);
				return RB'(r & ((64'd1 << w) - 1));
			end
		endcase
	endfunction

	initial begin
		bit [RB-1:0] directed[$];
		directed = '{0, 1, 2, 3, 4, 5, 7, 13, 61, 109, 181, 661, 991,
			{RB{1'b1}}, {1'b1, {(RB-1){1'b0}}}, {RB/2{2'b10}}, {RB/2{2'b01}},
			40'd1048575 * 40'd1048575, 40'd1048575 * 40'd1048575 - 1,
			40'd1048576 * 40'd1048576 - 2, 40'd999999999989, 40'd4294967295};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send_word(directed[i]);
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 22 : (phase == 1) ? 50 : 0;
			repeat (26) send_word(random_radicand());
		end
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_pell_fundamental_solution: PASS");
		end else begin
			$display("tb_pell_fundamental_solution: FAIL");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/pfs_pkg.sv
rtl/pell_fundamental_solution.sv
verif/tb_pell_fundamental_solution.sv
